### rtl/slru_pkg.sv
// ============================================================================
// slru_pkg
// Shared types and constants for the set-associative LRU cache simulator.
// ============================================================================
`default_nettype none

package slru_pkg;

  // Default geometry limits
  localparam int DEF_MAX_SET_BITS = 6;
  localparam int DEF_MAX_WAYS     = 8;
  localparam int DEF_STAMP_WIDTH  = 32;

  // Fixed field widths
  localparam int ADDR_W  = 64;
  localparam int CNT_W   = 32;
  localparam int SETB_W  = 3;
  localparam int BLKB_W  = 5;
  localparam int WAYS_W  = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  // Output tdata: hit, miss, eviction, three totals, zero-filled to bytes
  localparam int RES_BITS   = 3 + 3 * CNT_W;
  localparam int M_TDATA_W  = ((RES_BITS + 7) / 8) * 8;
  localparam int M_PAD_W    = M_TDATA_W - RES_BITS;

  // Access queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SET_BITS   = 2'd0,
    CFG_BLOCK_BITS = 2'd1,
    CFG_WAYS       = 2'd2
  } cfg_index_t;

  // One result item
  typedef struct packed {
    logic             last;
    logic [CNT_W-1:0] eviction_total;
    logic [CNT_W-1:0] miss_total;
    logic [CNT_W-1:0] hit_total;
    logic             eviction;
    logic             miss;
    logic             hit;
  } slru_result_t;

endpackage

`default_nettype wire

### rtl/set_assoc_lru_cache_sim.sv
// ============================================================================
// set_assoc_lru_cache_sim
// Set-associative cache tag simulator with LRU replacement and running
// hit, miss and eviction totals.
// ============================================================================
// Usage:
//   s_* takes one access request per item: tdata is the byte address, tuser
//   the kind (0 load/store, one result; 1 modify, two results, tlast on the
//   second). m_* gives one result item per access. cfg_* writes set_bits,
//   block_bits and ways by index; write it only while the block is idle.
//   Path: an accepted request enters the access queue; the back end then
//   reads its set row, does the lookup and row write-back, and registers
//   the result item. It takes no new access before that write-back; a modify
//   item passes through the back end twice. A 4-entry access queue lets the
//   front keep taking requests while the back end works.
//   Reset: synchronous. Afterwards a clearing pass walks the tag store one
//   set row per cycle, all 2^MAX_SET_BITS rows (64 by default); s_tready
//   stays low until it ends. Config writes are taken at any time.
//   Stall: a result held on m_* blocks the next write-back; the queue then
//   fills and s_tready drops.
// ============================================================================
`default_nettype none

module set_assoc_lru_cache_sim #(
  parameter int MAX_SET_BITS = slru_pkg::DEF_MAX_SET_BITS,
  parameter int MAX_WAYS     = slru_pkg::DEF_MAX_WAYS,
  parameter int STAMP_WIDTH  = slru_pkg::DEF_STAMP_WIDTH
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // Request stream
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [slru_pkg::ADDR_W-1:0]      s_tdata,   // [63:0] addr
  input  wire logic [0:0]                       s_tuser,   // [0] op
  // Result stream
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // [0] hit, [1] miss, [2] eviction, [34:3] hit_total, [66:35] miss_total,
  // [98:67] eviction_total, [103:99] zero
  output logic [slru_pkg::M_TDATA_W-1:0]        m_tdata,
  output logic                                  m_tlast,
  // Configuration writes
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [slru_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [slru_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int QW    = SET_W + slru_pkg::ADDR_W + 1;

  logic [slru_pkg::SETB_W-1:0] set_bits;
  logic [slru_pkg::BLKB_W-1:0] block_bits;
  logic [slru_pkg::WAYS_W-1:0] ways;

  logic          clr_busy;
  logic          push_valid;
  logic          push_ready;
  logic [QW-1:0] push_data;
  logic          pop_valid;
  logic          pop_ready;
  logic [QW-1:0] pop_data;

  slru_pkg::slru_result_t res;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits   <= '0;
      block_bits <= '0;
      ways       <= slru_pkg::WAYS_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (slru_pkg::cfg_index_t'(cfg_index))
        slru_pkg::CFG_SET_BITS:   set_bits   <= cfg_data[slru_pkg::SETB_W-1:0];
        slru_pkg::CFG_BLOCK_BITS: block_bits <= cfg_data[slru_pkg::BLKB_W-1:0];
        slru_pkg::CFG_WAYS:       ways       <= cfg_data[slru_pkg::WAYS_W-1:0];
        default: ;
      endcase
    end
  end

  slru_front #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .SET_W        (SET_W),
    .QW           (QW)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .set_bits   (set_bits),
    .block_bits (block_bits),
    .clr_busy   (clr_busy),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_op       (s_tuser[0]),
    .s_addr     (s_tdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  slru_queue #(
    .W     (QW),
    .DEPTH (slru_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  slru_back #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS),
    .STAMP_WIDTH  (STAMP_WIDTH),
    .SET_W        (SET_W),
    .QW           (QW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .ways      (ways),
    .q_valid   (pop_valid),
    .q_ready   (pop_ready),
    .q_data    (pop_data),
    .clr_busy  (clr_busy),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  // Result packing
  assign m_tdata = {{slru_pkg::M_PAD_W{1'b0}}, res.eviction_total, res.miss_total,
                    res.hit_total, res.eviction, res.miss, res.hit};
  assign m_tlast = res.last;

endmodule

`default_nettype wire

### rtl/slru_queue.sv
// ============================================================================
// slru_queue
// Small register FIFO carrying decoded accesses from front to back.
// ============================================================================
`default_nettype none

module slru_queue #(
  parameter int W     = 8,
  parameter int DEPTH = slru_pkg::QUEUE_DEPTH
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push_valid,
  output logic              push_ready,
  input  wire logic [W-1:0] push_data,
  output logic              pop_valid,
  input  wire logic         pop_ready,
  output logic [W-1:0]      pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     q_mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = q_mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/slru_front.sv
// ============================================================================
// slru_front
// Accepts input items, splits a modify into two accesses and derives the
// set index and tag of each access for the back end.
// ============================================================================
`default_nettype none

module slru_front #(
  parameter int MAX_SET_BITS = slru_pkg::DEF_MAX_SET_BITS,
  parameter int SET_W        = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1,
  parameter int QW           = SET_W + slru_pkg::ADDR_W + 1
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [slru_pkg::SETB_W-1:0] set_bits,
  input  wire logic [slru_pkg::BLKB_W-1:0] block_bits,
  input  wire logic                        clr_busy,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic                        s_op,
  input  wire logic [slru_pkg::ADDR_W-1:0] s_addr,
  output logic                             push_valid,
  input  wire logic                        push_ready,
  output logic [QW-1:0]                    push_data
);

  localparam int SB_CLOG = $clog2(MAX_SET_BITS + 1);
  localparam int SB_W    = (SB_CLOG > slru_pkg::SETB_W) ? SB_CLOG : slru_pkg::SETB_W;
  localparam int SH_W    = 7;
  localparam int AW      = slru_pkg::ADDR_W;

  logic [SB_W-1:0]  sbx;
  logic [SB_W-1:0]  sb;
  logic [AW-1:0]    shifted;
  logic [AW-1:0]    set_mask;
  logic [AW-1:0]    set_full;
  logic [SET_W-1:0] set_idx;
  logic [AW-1:0]    tag;
  logic             accept;

  // Second access of a modify waits here
  logic             rep_valid;
  logic [SET_W-1:0] rep_set;
  logic [AW-1:0]    rep_tag;

  // Address split with clamped set bit count
  always_comb begin
    sbx      = SB_W'(set_bits);
    sb       = (sbx > SB_W'(MAX_SET_BITS)) ? SB_W'(MAX_SET_BITS) : sbx;
    shifted  = s_addr >> block_bits;
    set_mask = (AW'(1) << sb) - AW'(1);
    set_full = shifted & set_mask;
    set_idx  = set_full[SET_W-1:0];
    tag      = s_addr >> (SH_W'(block_bits) + SH_W'(sb));
  end

  assign s_tready   = !clr_busy && !rep_valid && push_ready;
  assign accept     = s_tvalid && s_tready;
  assign push_valid = rep_valid || accept;
  // Queue entry: tag low, then set, last on top
  assign push_data  = rep_valid ? {1'b1, rep_set, rep_tag} : {!s_op, set_idx, tag};

  always_ff @(posedge clk) begin
    if (rst) begin
      rep_valid <= 1'b0;
    end else begin
      if (rep_valid && push_ready) begin
        rep_valid <= 1'b0;
      end
      if (accept && s_op) begin
        rep_valid <= 1'b1;
        rep_set   <= set_idx;
        rep_tag   <= tag;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/slru_back.sv
// ============================================================================
// slru_back
// Tag store and LRU engine: reads one set row, resolves hit, fill or
// eviction, writes the row back and registers the result item.
// ============================================================================
`default_nettype none

module slru_back #(
  parameter int MAX_SET_BITS = slru_pkg::DEF_MAX_SET_BITS,
  parameter int MAX_WAYS     = slru_pkg::DEF_MAX_WAYS,
  parameter int STAMP_WIDTH  = slru_pkg::DEF_STAMP_WIDTH,
  parameter int SET_W        = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1,
  parameter int QW           = SET_W + slru_pkg::ADDR_W + 1
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [slru_pkg::WAYS_W-1:0] ways,
  input  wire logic                        q_valid,
  output logic                             q_ready,
  input  wire logic [QW-1:0]               q_data,
  output logic                             clr_busy,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output slru_pkg::slru_result_t           out_res
);

  localparam int ROWS  = 1 << MAX_SET_BITS;
  localparam int AW    = slru_pkg::ADDR_W;
  localparam int CW    = slru_pkg::CNT_W;
  localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int NW_W  = $clog2(MAX_WAYS + 1);
  localparam int WC_W  = (NW_W > slru_pkg::WAYS_W) ? NW_W : slru_pkg::WAYS_W;

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_LOOK} state_t;

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
    sat_inc = (v == '1) ? v : v + 1'b1;
  endfunction

  state_t state;

  // Row memory: one row per set, all ways side by side
  logic [MAX_WAYS-1:0]                  mem_valid [ROWS];
  logic [MAX_WAYS-1:0][AW-1:0]          mem_tag   [ROWS];
  logic [MAX_WAYS-1:0][STAMP_WIDTH-1:0] mem_stamp [ROWS];

  logic [MAX_WAYS-1:0]                  rd_valid;
  logic [MAX_WAYS-1:0][AW-1:0]          rd_tag;
  logic [MAX_WAYS-1:0][STAMP_WIDTH-1:0] rd_stamp;

  logic                                 rd_en;
  logic [SET_W-1:0]                     rd_addr;
  logic                                 mem_we;
  logic [SET_W-1:0]                     mem_waddr;
  logic [MAX_WAYS-1:0]                  wr_valid;

  // Access being worked on
  logic [SET_W-1:0]       acc_set;
  logic [AW-1:0]          acc_tag;
  logic                   acc_last;
  logic [SET_W-1:0]       clr_idx;
  logic [STAMP_WIDTH-1:0] access_clock;
  logic [STAMP_WIDTH-1:0] clock_next;
  logic [CW-1:0]          hit_cnt;
  logic [CW-1:0]          miss_cnt;
  logic [CW-1:0]          evict_cnt;

  // Lookup results
  logic [WC_W-1:0]  ways_ext;
  logic [NW_W-1:0]  nw;
  logic             hit_any;
  logic [WAY_W-1:0] hit_way;
  logic             inv_any;
  logic [WAY_W-1:0] inv_way;
  logic [WAY_W-1:0] lru_way;
  logic [WAY_W-1:0] victim;
  logic             evict;
  logic             advance;

  logic [MAX_WAYS-1:0]                  row_valid_nx;
  logic [MAX_WAYS-1:0][AW-1:0]          row_tag_nx;
  logic [MAX_WAYS-1:0][STAMP_WIDTH-1:0] row_stamp_nx;
  logic [CW-1:0]                        hit_cnt_nx;
  logic [CW-1:0]                        miss_cnt_nx;
  logic [CW-1:0]                        evict_cnt_nx;

  assign q_ready  = (state == ST_IDLE);
  assign rd_en    = q_ready && q_valid;
  assign rd_addr  = q_data[AW +: SET_W];
  assign clr_busy = (state == ST_CLEAR);
  assign advance  = (state == ST_LOOK) && (!out_valid || out_ready);

  assign clock_next = access_clock + 1'b1;

  // Clamp the way count to 1..MAX_WAYS
  always_comb begin
    ways_ext = WC_W'(ways);
    if (ways_ext == '0) begin
      nw = NW_W'(1);
    end else if (ways_ext > WC_W'(MAX_WAYS)) begin
      nw = NW_W'(MAX_WAYS);
    end else begin
      nw = NW_W'(ways_ext);
    end
  end

  // Tag match, first free way and oldest way over the row
  always_comb begin
    hit_any = 1'b0;
    hit_way = '0;
    inv_any = 1'b0;
    inv_way = '0;
    lru_way = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (NW_W'(w) < nw) begin
        if (rd_valid[w] && (rd_tag[w] == acc_tag) && !hit_any) begin
          hit_any = 1'b1;
          hit_way = WAY_W'(w);
        end
        if (!rd_valid[w] && !inv_any) begin
          inv_any = 1'b1;
          inv_way = WAY_W'(w);
        end
        if ((w > 0) && (rd_stamp[w] < rd_stamp[lru_way])) begin
          lru_way = WAY_W'(w);
        end
      end
    end
  end

  // Row update and counters
  always_comb begin
    evict  = !hit_any && !inv_any;
    victim = hit_any ? hit_way : (inv_any ? inv_way : lru_way);
    row_valid_nx         = rd_valid;
    row_tag_nx           = rd_tag;
    row_stamp_nx         = rd_stamp;
    row_valid_nx[victim] = 1'b1;
    row_tag_nx[victim]   = acc_tag;
    row_stamp_nx[victim] = clock_next;
    hit_cnt_nx   = hit_any ? sat_inc(hit_cnt) : hit_cnt;
    miss_cnt_nx  = hit_any ? miss_cnt : sat_inc(miss_cnt);
    evict_cnt_nx = evict ? sat_inc(evict_cnt) : evict_cnt;
  end

  // Write port: clearing pass or row write-back
  assign mem_we    = (state == ST_CLEAR) || advance;
  assign mem_waddr = (state == ST_CLEAR) ? clr_idx : acc_set;
  assign wr_valid  = (state == ST_CLEAR) ? '0 : row_valid_nx;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_valid[mem_waddr] <= wr_valid;
      mem_tag[mem_waddr]   <= row_tag_nx;
      mem_stamp[mem_waddr] <= row_stamp_nx;
    end
    if (rd_en) begin
      rd_valid <= mem_valid[rd_addr];
      rd_tag   <= mem_tag[rd_addr];
      rd_stamp <= mem_stamp[rd_addr];
    end
  end

  // Sequencer, counters and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_idx      <= '0;
      out_valid    <= 1'b0;
      access_clock <= '0;
      hit_cnt      <= '0;
      miss_cnt     <= '0;
      evict_cnt    <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == SET_W'(ROWS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (rd_en) begin
            acc_tag  <= q_data[AW-1:0];
            acc_set  <= rd_addr;
            acc_last <= q_data[QW-1];
            state    <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          if (advance) begin
            access_clock           <= clock_next;
            hit_cnt                <= hit_cnt_nx;
            miss_cnt               <= miss_cnt_nx;
            evict_cnt              <= evict_cnt_nx;
            out_valid              <= 1'b1;
            out_res.hit            <= hit_any;
            out_res.miss           <= !hit_any;
            out_res.eviction       <= evict;
            out_res.hit_total      <= hit_cnt_nx;
            out_res.miss_total     <= miss_cnt_nx;
            out_res.eviction_total <= evict_cnt_nx;
            out_res.last           <= acc_last;
            state                  <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Checks
  a_hit_xor_miss: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_res.hit != out_res.miss))
    else $error("result is not exactly one of hit or miss");

  a_evict_is_miss: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.eviction) |-> out_res.miss)
    else $error("eviction reported on a hit");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    advance |=> (out_valid && (out_res.miss_total == miss_cnt)))
    else $error("write-back did not load the result register");

  a_miss_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (miss_cnt >= $past(miss_cnt)))
    else $error("miss counter went backwards");

endmodule

`default_nettype wire

### test/slru_checker.sv
// ============================================================================
// slru_checker
// Watches the request, result and configuration channels of the LRU cache
// tag simulator, keeps its own copy of the tag store and totals, and compares
// every result item against the predicted lookup outcome in order.
// ============================================================================

package slru_tb_pkg;

  // Access kind carried in s_tuser
  typedef enum logic {
    ACC_SINGLE = 1'b0,
    ACC_MODIFY = 1'b1
  } access_kind_t;

endpackage

module slru_checker
  import slru_pkg::*, slru_tb_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  input  wire logic                   s_tready,
  input  wire logic [ADDR_W-1:0]      s_tdata,
  input  wire logic [0:0]             s_tuser,
  input  wire logic                   m_tvalid,
  input  wire logic                   m_tready,
  input  wire logic [M_TDATA_W-1:0]   m_tdata,
  input  wire logic                   m_tlast,
  input  wire logic                   cfg_valid,
  input  wire logic                   cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  output int                          mismatch_count,
  output int                          outstanding
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETS_MAX   = 1 << DEF_MAX_SET_BITS;
  localparam int LINES      = SETS_MAX * DEF_MAX_WAYS;
  localparam int REPORT_MAX = 10;

  // Shadow tag store, indexed set * DEF_MAX_WAYS + way
  bit                         line_ok  [LINES];
  logic [ADDR_W-1:0]          line_tag_q [LINES];
  logic [DEF_STAMP_WIDTH-1:0] line_age [LINES];
  logic [DEF_STAMP_WIDTH-1:0] access_tick;
  logic [CNT_W-1:0]           hits, misses, evictions;

  // Shadow geometry registers
  logic [SETB_W-1:0]          set_bits_q;
  logic [BLKB_W-1:0]          block_bits_q;
  logic [WAYS_W-1:0]          ways_q;

  // Lookup outcomes still owed by the block, oldest first
  slru_result_t               outcomes_due [$];

  function automatic logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic string show(slru_result_t r);
    return $sformatf("hit=%0b miss=%0b evict=%0b hits=%0d misses=%0d evicts=%0d last=%0b",
                     r.hit, r.miss, r.eviction, r.hit_total, r.miss_total,
                     r.eviction_total, r.last);
  endfunction

  // One cache access: look up, refresh or fill, and queue the outcome
  task automatic lookup_access(input logic [ADDR_W-1:0] addr, input logic is_last);
    int unsigned       sb, nw, base, pick;
    logic [ADDR_W-1:0] set_idx, tag_v;
    bit                was_hit, evicted, free_found;
    slru_result_t      r;
    sb = (set_bits_q > DEF_MAX_SET_BITS) ? DEF_MAX_SET_BITS : set_bits_q;
    nw = (ways_q == 0) ? 1 : ((ways_q > DEF_MAX_WAYS) ? DEF_MAX_WAYS : ways_q);
    set_idx = (addr >> block_bits_q) & ((64'd1 << sb) - 64'd1);
    tag_v   = addr >> (block_bits_q + sb);
    base    = set_idx * DEF_MAX_WAYS;
    was_hit = 1'b0;
    evicted = 1'b0;
    access_tick = access_tick + 1'b1;

    for (int w = 0; w < nw; w++) begin
      if (!was_hit && line_ok[base + w] && line_tag_q[base + w] == tag_v) begin
        line_age[base + w] = access_tick;
        was_hit = 1'b1;
      end
    end

    if (was_hit) begin
      hits = bump(hits);
    end else begin
      misses = bump(misses);
      // lowest free way first, else the oldest stamp
      free_found = 1'b0;
      pick = 0;
      for (int w = 0; w < nw; w++) begin
        if (!free_found && !line_ok[base + w]) begin
          pick = w;
          free_found = 1'b1;
        end
      end
      if (!free_found) begin
        evicted = 1'b1;
        evictions = bump(evictions);
        pick = 0;
        for (int w = 1; w < nw; w++) begin
          if (line_age[base + w] < line_age[base + pick]) pick = w;
        end
      end
      line_ok[base + pick]    = 1'b1;
      line_tag_q[base + pick] = tag_v;
      line_age[base + pick]   = access_tick;
    end

    r.hit            = was_hit;
    r.miss           = !was_hit;
    r.eviction       = evicted;
    r.hit_total      = hits;
    r.miss_total     = misses;
    r.eviction_total = evictions;
    r.last           = is_last;
    outcomes_due.push_back(r);
  endtask

  // Per-edge monitor: results first, then register writes, then requests
  always @(posedge clk) begin : monitor
    slru_result_t           got, want;
    logic [M_PAD_W-1:0]     pad;
    if (rst) begin
      foreach (line_ok[i]) begin
        line_ok[i]  = 1'b0;
        line_age[i] = '0;
      end
      access_tick    = '0;
      hits           = '0;
      misses         = '0;
      evictions      = '0;
      set_bits_q     = '0;
      block_bits_q   = '0;
      ways_q         = 4'd1;
      mismatch_count = 0;
      outcomes_due.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = slru_result_t'({m_tlast, m_tdata[RES_BITS-1:0]});
        pad = m_tdata[M_TDATA_W-1:RES_BITS];
        if (outcomes_due.size() == 0) begin
          if (mismatch_count < REPORT_MAX)
            $display("[%0t] unexpected result item: %s", $realtime, show(got));
          mismatch_count++;
        end else begin
          want = outcomes_due.pop_front();
          if (got !== want || pad !== '0) begin
            if (mismatch_count < REPORT_MAX) begin
              $display("[%0t] result mismatch", $realtime);
              $display("  expected %s pad=0", show(want));
              $display("  actual   %s pad=%0h", show(got), pad);
            end
            mismatch_count++;
          end
        end
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SET_BITS:   set_bits_q   = cfg_data[SETB_W-1:0];
          CFG_BLOCK_BITS: block_bits_q = cfg_data[BLKB_W-1:0];
          CFG_WAYS:       ways_q       = cfg_data[WAYS_W-1:0];
          default: ;
        endcase
      end

      if (s_tvalid && s_tready) begin
        if (s_tuser[0] == ACC_MODIFY) begin
          lookup_access(s_tdata, 1'b0);
          lookup_access(s_tdata, 1'b1);
        end else begin
          lookup_access(s_tdata, 1'b1);
        end
      end
    end
    outstanding = outcomes_due.size();
  end

endmodule

### test/tb_top.sv
// ============================================================================
// tb_top
// Drives the LRU cache tag simulator with directed and random accesses over
// a series of cache geometries, with random stalls on both streams, and
// reports the verdict from the checker's mismatch count.
// ============================================================================

module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  import slru_pkg::*;
  import slru_tb_pkg::*;

  localparam int STUCK_LIMIT  = 2000;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 55;
  localparam int POOL_MAX     = 64;
  localparam int TAIL_CYCLES  = 8;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [ADDR_W-1:0]      s_tdata = '0;
  logic [0:0]             s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [M_TDATA_W-1:0]   m_tdata;
  logic                   m_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  cfg_index_t             cfg_index = CFG_SET_BITS;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int                     mismatch_count;
  int                     outstanding;
  bit                     calm = 1'b0;   // no idling on either side
  int                     stall_left = 0;
  int                     stuck_cycles = 0;

  set_assoc_lru_cache_sim i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  slru_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tlast        (m_tlast),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic logic [ADDR_W-1:0] rand_addr();
    return {$urandom, $urandom};
  endfunction

  // Result side back-pressure
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      stall_left = ($urandom_range(0, 2) == 0) ? idle_len() : 0;
      m_tready <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // Watchdog: cycles with no item moving on any channel
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("FAIL set_assoc_lru_cache_sim");
      $finish;
    end
  end

  // One register write; cfg_valid stays high for the caller to lower
  task automatic put_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_geometry(input logic [SETB_W-1:0] sb, input logic [BLKB_W-1:0] bb,
                               input logic [WAYS_W-1:0] nw);
    put_reg(CFG_SET_BITS, CFG_DATA_W'(sb));
    put_reg(CFG_BLOCK_BITS, CFG_DATA_W'(bb));
    put_reg(CFG_WAYS, CFG_DATA_W'(nw));
    cfg_valid <= 1'b0;
  endtask

  // Offer one request item, after a random gap, and wait for acceptance
  task automatic send_access(input access_kind_t kind, input logic [ADDR_W-1:0] addr);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= addr;
    s_tuser  <= kind;
    do @(posedge clk); while (!s_tready);
  endtask

  // Hold off requests until every predicted result has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [ADDR_W-1:0] pool [POOL_MAX];
    logic [ADDR_W-1:0] off_mask, addr;
    logic [SETB_W-1:0] sb;
    logic [BLKB_W-1:0] bb;
    logic [WAYS_W-1:0] nw;
    int                sb_eff, nw_eff, lines, pool_n;
    access_kind_t      kind;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Two sets, 16-byte blocks, two ways: fill, hit, LRU eviction, modify
    load_geometry(3'd1, 5'd4, 4'd2);
    send_access(ACC_SINGLE, 64'h0);
    send_access(ACC_SINGLE, 64'h0);
    send_access(ACC_SINGLE, '1);
    send_access(ACC_SINGLE, 64'h20);
    send_access(ACC_SINGLE, 64'h40);
    send_access(ACC_MODIFY, 64'hF);
    send_access(ACC_MODIFY, 64'h8000_0000_0000_0010);
    send_access(ACC_SINGLE, 64'h5555_5555_5555_5555);
    send_access(ACC_SINGLE, 64'hAAAA_AAAA_AAAA_AAAA);
    drain();

    // Registers above range: set bits and ways clamp; old lines kept
    load_geometry(3'd7, 5'd31, 4'd15);
    send_access(ACC_MODIFY, '1);
    send_access(ACC_SINGLE, 64'h0);
    send_access(ACC_SINGLE, 64'h0000_0000_8000_0000);
    send_access(ACC_SINGLE, 64'h0000_0020_0000_0000);
    send_access(ACC_SINGLE, 64'h0);
    drain();

    // Zero ways acts as direct mapped with a single set
    load_geometry(3'd0, 5'd0, 4'd0);
    send_access(ACC_SINGLE, 64'h0);
    send_access(ACC_SINGLE, 64'h1);
    send_access(ACC_MODIFY, 64'h0);
    send_access(ACC_SINGLE, '1);
    send_access(ACC_SINGLE, 64'h1);
    drain();

    // Random phases over a working set of hot blocks plus stray addresses
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin sb = 3'd0; bb = 5'd0;  nw = 4'd1;  end
        1: begin sb = 3'd6; bb = 5'd16; nw = 4'd8;  end
        2: begin sb = 3'd2; bb = 5'd31; nw = 4'd3;  end
        default: begin
          sb = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 3);
          bb = $urandom_range(0, 31);
          nw = $urandom_range(0, 15);
        end
      endcase
      load_geometry(sb, bb, nw);
      calm = (phase % 4 == 2);

      sb_eff = (sb > DEF_MAX_SET_BITS) ? DEF_MAX_SET_BITS : sb;
      nw_eff = (nw == 0) ? 1 : ((nw > DEF_MAX_WAYS) ? DEF_MAX_WAYS : nw);
      lines  = (1 << sb_eff) * nw_eff;
      pool_n = $urandom_range(1, (2 * lines + 1 > POOL_MAX) ? POOL_MAX : 2 * lines + 1);
      for (int i = 0; i < pool_n; i++) pool[i] = rand_addr();
      off_mask = (64'd1 << bb) - 64'd1;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 3 && n == PHASE_ITEMS / 2) drain();
        kind = ($urandom_range(0, 2) == 0) ? ACC_MODIFY : ACC_SINGLE;
        if ($urandom_range(0, 9) < 8)
          addr = (pool[$urandom_range(0, pool_n - 1)] & ~off_mask) | (rand_addr() & off_mask);
        else
          addr = rand_addr();
        send_access(kind, addr);
      end
      drain();
    end

    calm = 1'b0;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0)
      $display("PASS set_assoc_lru_cache_sim");
    else
      $display("FAIL set_assoc_lru_cache_sim");
    $finish;
  end

endmodule
